// ===== rtl/core/pacc_pkg.sv =====
`timescale 1ns / 1ps

package pacc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int StepW = 5;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;

    typedef struct packed {
        logic signed [31:0] rot_00;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_10;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_20;
        logic signed [31:0] rot_21;
        logic signed [31:0] rot_22;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } pose_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] heading;
    } pose_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CORDIC,
        ST_DONE
    } pacc_state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mac;
    } mac_ctrl_t;

    function automatic logic signed [31:0] atan_q29(input logic [StepW-1:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0: v = 32'sd421657428;
            5'd1: v = 32'sd248918915;
            5'd2: v = 32'sd131521918;
            5'd3: v = 32'sd66762579;
            5'd4: v = 32'sd33510844;
            5'd5: v = 32'sd16771758;
            5'd6: v = 32'sd8387925;
            5'd7: v = 32'sd4194218;
            5'd8: v = 32'sd2097141;
            5'd9: v = 32'sd1048575;
            5'd30: v = 32'sd0;
            5'd31: v = 32'sd0;
            default: v = 32'sd1 <<< (5'd29 - i);
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/pacc_mac.sv =====
`timescale 1ns / 1ps

module pacc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  pacc_pkg::mac_ctrl_t ctrl,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    input  logic signed [31:0]  init,
    output logic signed [35:0]  acc
);
    import pacc_pkg::*;

    logic signed [63:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [35:0] acc_reg;
    logic signed [63:0] rnd;

    assign rnd = prod_reg + 64'sd536870912;
    assign acc = acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mac;
            if (ctrl.clear)
                acc_reg <= {{4{init[31]}}, init};
            else if (prod_vld_reg)
                acc_reg <= acc_reg + 36'(rnd >>> 30);
        end
    end

endmodule

// ===== rtl/core/pacc_cordic.sv =====
`timescale 1ns / 1ps

module pacc_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] fwd_x,
    input  logic signed [31:0] fwd_z,
    output logic               done,
    output logic signed [31:0] angle
);
    import pacc_pkg::*;

    logic signed [34:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [StepW:0]     step_reg;
    logic               busy_reg;
    logic signed [34:0] xs, ys;
    logic [StepW-1:0]   si;

    assign si = step_reg[StepW-1:0];
    assign xs = x_reg >>> si;
    assign ys = y_reg >>> si;
    assign done = busy_reg && (step_reg == (StepW+1)'(CORDIC_STEPS));

    always_comb
    begin
        if (z_reg > PI_Q29)
            angle = PI_Q29[31:0];
        else if (z_reg < -PI_Q29)
            angle = 32'(-PI_Q29);
        else
            angle = z_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            z_reg    <= '0;
            if (fwd_z == 0 && fwd_x == 0)
            begin
                // zero vector: skip iterations, angle stays zero
                step_reg <= (StepW+1)'(CORDIC_STEPS);
                x_reg    <= '0;
                y_reg    <= '0;
            end
            else if (fwd_z < 0)
            begin
                if (fwd_x >= 0)
                begin
                    x_reg <= 35'(fwd_x);
                    y_reg <= -35'(fwd_z);
                    z_reg <= HALF_PI_Q29;
                end
                else
                begin
                    x_reg <= -35'(fwd_x);
                    y_reg <= 35'(fwd_z);
                    z_reg <= -HALF_PI_Q29;
                end
            end
            else
            begin
                x_reg <= 35'(fwd_z);
                y_reg <= 35'(fwd_x);
            end
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 34'(atan_q29(si));
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 34'(atan_q29(si));
            end
        end
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= (StepW+1)'(CORDIC_STEPS))
        else $error("cordic step past limit");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("cordic restarted while busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg)
        else $error("cordic busy after done");

endmodule

// ===== rtl/core/pose_accumulator_with_heading.sv =====
`timescale 1ns / 1ps
// channel | dir | valid     | stall     | payload
// in      | in  | in_valid  | in_stall  | in_data  (pose_in_t)
// out     | out | out_valid | out_stall | out_data (pose_out_t)
// One request takes 12 dot products of 3 products each on one shared multiplier.
// Each dot product has three issue steps and two drain steps.
// The iterative CORDIC follows, and a zero forward vector skips its iterations.
// Reset sets identity rotation, zero position.
// in_stall is high while a request is in work or its result waits on out_stall.
module pose_accumulator_with_heading (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pacc_pkg::pose_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pacc_pkg::pose_out_t out_data
);
    import pacc_pkg::*;

    pacc_state_t state_reg, state_next;
    logic signed [31:0] rw_reg [9];
    logic signed [31:0] pw_reg [3];
    logic signed [31:0] rn_reg [9];
    logic signed [31:0] d_reg  [9];
    logic signed [31:0] t_reg  [3];
    logic [3:0]  dot_reg;     // 0..2 position, 3..11 rotation
    logic [2:0]  k_reg;       // 0..2 issue, 3..4 drain
    logic        out_vld_reg;
    pose_out_t   out_reg;
    mac_ctrl_t   ctrl;
    logic signed [31:0] ma, mb, minit;
    logic signed [35:0] acc;
    logic [1:0]  row, col, kk;
    logic [3:0]  rj;
    logic        cstart, cdone;
    logic signed [31:0] angle;
    logic        accept, dot_end;
    logic        res_load;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign rj  = (dot_reg >= 4'd3) ? dot_reg - 4'd3 : 4'd0;
    assign row = (dot_reg < 4'd3) ? dot_reg[1:0] :
                 (rj >= 4'd6) ? 2'd2 : (rj >= 4'd3) ? 2'd1 : 2'd0;
    assign col = (rj >= 4'd6) ? 2'(rj - 4'd6) :
                 (rj >= 4'd3) ? 2'(rj - 4'd3) : rj[1:0];
    assign kk  = k_reg[1:0];
    assign dot_end = (state_reg == ST_MAC) && (k_reg == 3'd4);
    assign res_load = ((state_reg == ST_CORDIC && cdone) || state_reg == ST_DONE) &&
                      (!out_vld_reg || !out_stall);

    always_comb
    begin
        ma = rw_reg[4'(row) * 4'd3 + 4'(kk)];
        if (dot_reg < 4'd3)
            mb = t_reg[kk];
        else
            mb = d_reg[4'(kk) * 4'd3 + 4'(col)];
        minit = (dot_reg < 4'd3) ? pw_reg[row] : 32'sd0;
    end

    always_comb
    begin
        ctrl.clear = (state_reg == ST_MAC) && (k_reg == 3'd0);
        ctrl.mac   = (state_reg == ST_MAC) && (k_reg < 3'd3);
        cstart     = (state_reg == ST_MAC) && dot_end && (dot_reg == 4'd11);
    end

    pacc_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .a    (ma),
        .b    (mb),
        .init (minit),
        .acc  (acc)
    );

    // forward x is R[0][2], forward z is R[2][2] straight from the accumulator
    pacc_cordic u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cstart),
        .fwd_x(rn_reg[2]),
        .fwd_z(sat32(acc)),
        .done (cdone),
        .angle(angle)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_MAC;
            ST_MAC:    if (cstart) state_next = ST_CORDIC;
            ST_CORDIC: if (cdone) state_next = res_load ? ST_IDLE : ST_DONE;
            ST_DONE:   if (res_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg <= '{in_data.rot_00, in_data.rot_01, in_data.rot_02,
                       in_data.rot_10, in_data.rot_11, in_data.rot_12,
                       in_data.rot_20, in_data.rot_21, in_data.rot_22};
            t_reg <= '{in_data.move_x, in_data.move_y, in_data.move_z};
        end
        if (dot_end && dot_reg >= 4'd3)
            rn_reg[rj] <= sat32(acc);
        if (res_load)
        begin
            out_reg.heading <= angle;
            out_reg.pos_x   <= pw_reg[0];
            out_reg.pos_y   <= pw_reg[1];
            out_reg.pos_z   <= pw_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dot_reg     <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                rw_reg[i] <= (i % 4 == 0) ? ONE_Q30 : 32'sd0;
            for (int i = 0; i < 3; i++)
                pw_reg[i] <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
            if (accept)
            begin
                dot_reg <= '0;
                k_reg   <= '0;
            end
            else if (state_reg == ST_MAC)
            begin
                if (dot_end)
                begin
                    k_reg   <= '0;
                    dot_reg <= dot_reg + 1'b1;
                    if (dot_reg < 4'd3)
                        pw_reg[dot_reg[1:0]] <= sat32(acc);
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
            if (cstart)
            begin
                for (int i = 0; i < 8; i++)
                    rw_reg[i] <= rn_reg[i];
                rw_reg[8] <= sat32(acc);
            end
        end
    end

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> in_stall)
        else $error("accepting during work");
    a_dot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> dot_reg <= 4'd11 && k_reg <= 3'd4)
        else $error("sequencer counter out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |=> out_vld_reg && $stable(out_reg))
        else $error("result lost under stall");

endmodule
